@@ rtl/core/thick_segment_pixel_test_macros.svh @@
`ifndef THICK_SEGMENT_PIXEL_TEST_MACROS_SVH
`define THICK_SEGMENT_PIXEL_TEST_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  localparam int PIX_W      = 9;
  localparam int IDX_W      = 18;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // quotient bits of the projection parameter, one per divider stage
  localparam int DIV_BITS = 16;

  // pipeline stage positions in the valid shift register
  localparam int ST_DIV0 = 4;
  localparam int ST_T    = ST_DIV0 + DIV_BITS;
  localparam int ST_M    = ST_T + 1;
  localparam int ST_E    = ST_M + 1;
  localparam int ST_SQ   = ST_E + 1;
  localparam int STAGES  = ST_SQ + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_END_X       = 3'd2,
    REG_END_Y       = 3'd3,
    REG_LINE_WIDTH  = 3'd4,
    REG_PAINT_RED   = 3'd5,
    REG_PAINT_GREEN = 3'd6,
    REG_PAINT_BLUE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/thick_segment_pixel_test.sv @@
// Thick line pixel test, round caps. One pixel item per clock, back to back, while
// in_ready is high; each item gives one result. The pipeline has sixteen projection
// divider stages, one quotient bit of the clamped segment parameter per stage, plus eight
// stages of setup, clamp, multiply, offset and square; the compare is combinational. A two-entry output
// (output register plus skid) keeps in_ready high while one result waits; in_ready drops
// only when both entries are full, and the whole pipeline then holds. Segment ends and
// thickness are in 1/16 pixel; write configuration only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module thick_segment_pixel_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tsp_pkg::PIX_W-1:0]       pixel_col,
  input  logic [tsp_pkg::PIX_W-1:0]       pixel_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [tsp_pkg::IDX_W-1:0]       pixel_index,
  output logic [tsp_pkg::COLOR_W-1:0]     out_red,
  output logic [tsp_pkg::COLOR_W-1:0]     out_green,
  output logic [tsp_pkg::COLOR_W-1:0]     out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [19:0]        lw2;
    logic               ok;
    logic [17:0]        idx;
    logic [31:0]        len2;
    logic               tz;
    logic               tone;
    logic [31:0]        rem;
    logic [15:0]        quo;
  } div_t;

  // restoring division step: one quotient bit
  function automatic div_t div_step(div_t d);
    logic [32:0] r2;
    logic [32:0] diff;
    div_t        o;
    o    = d;
    r2   = {d.rem, 1'b0};
    diff = r2 - {1'b0, d.len2};
    if (!diff[32]) begin
      o.rem = diff[31:0];
      o.quo = {d.quo[14:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.quo = {d.quo[14:0], 1'b0};
    end
    return o;
  endfunction

  // configuration registers
  logic signed [14:0] start_x, start_y, end_x, end_y;
  logic [9:0]         line_width;
  logic [7:0]         paint_red, paint_green, paint_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= '0;
      end_y       <= '0;
      line_width  <= 10'd128;
      paint_red   <= '0;
      paint_green <= '0;
      paint_blue  <= '0;
    end else if (cfg_valid) begin
      case (tsp_pkg::cfg_reg_t'(cfg_index))
        tsp_pkg::REG_START_X:     start_x     <= cfg_data;
        tsp_pkg::REG_START_Y:     start_y     <= cfg_data;
        tsp_pkg::REG_END_X:       end_x       <= cfg_data;
        tsp_pkg::REG_END_Y:       end_y       <= cfg_data;
        tsp_pkg::REG_LINE_WIDTH:  line_width  <= cfg_data[9:0];
        tsp_pkg::REG_PAINT_RED:   paint_red   <= cfg_data[7:0];
        tsp_pkg::REG_PAINT_GREEN: paint_green <= cfg_data[7:0];
        tsp_pkg::REG_PAINT_BLUE:  paint_blue  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control: whole pipe moves unless the skid entry is full
  logic                       en;
  logic [tsp_pkg::STAGES-1:0] vld;
  logic                       skid_valid;
  logic                       iv;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign iv       = vld[tsp_pkg::STAGES-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tsp_pkg::STAGES-2:0], in_valid};
    end
  end

  // stage 0: input register
  logic [8:0] s0_col, s0_row;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_col <= pixel_col;
      s0_row <= pixel_row;
    end
  end

  // stage 1: offsets, direction, index
  logic signed [15:0] s1_rx, s1_ry, s1_dx, s1_dy;
  logic               s1_ok;
  logic [17:0]        s1_idx;
  logic signed [15:0] dx1, dy1;
  logic               inimg1;

  always_comb begin
    dx1    = {end_x[14], end_x} - {start_x[14], start_x};
    dy1    = {end_y[14], end_y} - {start_y[14], start_y};
    inimg1 = (32'(s0_col) < 32'(tsp_pkg::IMAGE_WIDTH)) &&
             (32'(s0_row) < 32'(tsp_pkg::IMAGE_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rx  <= $signed({3'b000, s0_col, 4'b0000}) - $signed({start_x[14], start_x});
      s1_ry  <= $signed({3'b000, s0_row, 4'b0000}) - $signed({start_y[14], start_y});
      s1_dx  <= dx1;
      s1_dy  <= dy1;
      s1_ok  <= inimg1 && ((dx1 != '0) || (dy1 != '0));
      s1_idx <= 18'(32'(s0_row) * 32'(tsp_pkg::IMAGE_WIDTH) + 32'(s0_col));
    end
  end

  // stage 2: products
  logic signed [31:0] s2_dxdx, s2_dydy, s2_rxdx, s2_rydy;
  logic [19:0]        s2_lw2;
  logic signed [15:0] s2_rx, s2_ry, s2_dx, s2_dy;
  logic               s2_ok;
  logic [17:0]        s2_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dxdx <= 32'(s1_dx) * 32'(s1_dx);
      s2_dydy <= 32'(s1_dy) * 32'(s1_dy);
      s2_rxdx <= 32'(s1_rx) * 32'(s1_dx);
      s2_rydy <= 32'(s1_ry) * 32'(s1_dy);
      s2_lw2  <= 20'(line_width) * 20'(line_width);
      s2_rx   <= s1_rx;
      s2_ry   <= s1_ry;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_ok   <= s1_ok;
      s2_idx  <= s1_idx;
    end
  end

  // stage 3: squared length and dot product
  logic [31:0]        s3_len2;
  logic signed [32:0] s3_dot;
  logic [19:0]        s3_lw2;
  logic signed [15:0] s3_rx, s3_ry, s3_dx, s3_dy;
  logic               s3_ok;
  logic [17:0]        s3_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_len2 <= $unsigned(s2_dxdx) + $unsigned(s2_dydy);
      s3_dot  <= {s2_rxdx[31], s2_rxdx} + {s2_rydy[31], s2_rydy};
      s3_lw2  <= s2_lw2;
      s3_rx   <= s2_rx;
      s3_ry   <= s2_ry;
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_ok   <= s2_ok;
      s3_idx  <= s2_idx;
    end
  end

  // divider entry: clamp flags, remainder starts at the dot product
  div_t d_in;

  always_comb begin
    d_in.rx   = s3_rx;
    d_in.ry   = s3_ry;
    d_in.dx   = s3_dx;
    d_in.dy   = s3_dy;
    d_in.lw2  = s3_lw2;
    d_in.ok   = s3_ok;
    d_in.idx  = s3_idx;
    d_in.len2 = s3_len2;
    d_in.tz   = s3_dot[32] || (s3_dot == '0);
    d_in.tone = s3_dot >= $signed({1'b0, s3_len2});
    d_in.rem  = s3_dot[31:0];
    d_in.quo  = '0;
  end

  div_t dst [tsp_pkg::DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dst[0] <= div_step(d_in);
    end
  end

  for (genvar k = 1; k < tsp_pkg::DIV_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dst[k] <= div_step(dst[k-1]);
      end
    end
  end

  // stage T: clamped parameter, unsigned Q1.16 with 1.0 = 65536
  div_t        dlast;
  logic [16:0] st_t;
  logic signed [15:0] st_rx, st_ry, st_dx, st_dy;
  logic [19:0] st_lw2;
  logic        st_ok;
  logic [17:0] st_idx;

  assign dlast = dst[tsp_pkg::DIV_BITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (dlast.tz) begin
        st_t <= '0;
      end else if (dlast.tone) begin
        st_t <= 17'h10000;
      end else begin
        st_t <= {1'b0, dlast.quo};
      end
      st_rx  <= dlast.rx;
      st_ry  <= dlast.ry;
      st_dx  <= dlast.dx;
      st_dy  <= dlast.dy;
      st_lw2 <= dlast.lw2;
      st_ok  <= dlast.ok;
      st_idx <= dlast.idx;
    end
  end

  // stage M: t times direction
  logic signed [33:0] sm_tdx, sm_tdy;
  logic signed [15:0] sm_rx, sm_ry;
  logic [19:0]        sm_lw2;
  logic               sm_ok;
  logic [17:0]        sm_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      sm_tdx <= 34'($signed({1'b0, st_t})) * 34'(st_dx);
      sm_tdy <= 34'($signed({1'b0, st_t})) * 34'(st_dy);
      sm_rx  <= st_rx;
      sm_ry  <= st_ry;
      sm_lw2 <= st_lw2;
      sm_ok  <= st_ok;
      sm_idx <= st_idx;
    end
  end

  // stage E: offset from projected point, magnitude stays below 2^31
  logic signed [33:0] ex, ey, exn, eyn;
  logic [30:0]        se_ax, se_ay;
  logic [19:0]        se_lw2;
  logic               se_ok;
  logic [17:0]        se_idx;

  always_comb begin
    ex  = $signed({{2{sm_rx[15]}}, sm_rx, 16'h0000}) - sm_tdx;
    ey  = $signed({{2{sm_ry[15]}}, sm_ry, 16'h0000}) - sm_tdy;
    exn = -ex;
    eyn = -ey;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_ax  <= ex[33] ? exn[30:0] : ex[30:0];
      se_ay  <= ey[33] ? eyn[30:0] : ey[30:0];
      se_lw2 <= sm_lw2;
      se_ok  <= sm_ok;
      se_idx <= sm_idx;
    end
  end

  // stage SQ: squares
  logic [61:0] sq_ax2, sq_ay2;
  logic [19:0] sq_lw2;
  logic        sq_ok;
  logic [17:0] sq_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ax2 <= 62'(se_ax) * 62'(se_ax);
      sq_ay2 <= 62'(se_ay) * 62'(se_ay);
      sq_lw2 <= se_lw2;
      sq_ok  <= se_ok;
      sq_idx <= se_idx;
    end
  end

  // final compare: 4*dist^2 <= width^2, both scaled by 2^32
  logic [62:0]      d2;
  logic [62:0]      lim;
  logic             hit_c;
  tsp_pkg::result_t res_c;

  always_comb begin
    d2          = {1'b0, sq_ax2} + {1'b0, sq_ay2};
    lim         = {13'd0, sq_lw2, 30'd0};
    hit_c       = sq_ok && (d2 <= lim);
    res_c.hit         = hit_c;
    res_c.pixel_index = sq_idx;
    res_c.red         = hit_c ? paint_red   : '0;
    res_c.green       = hit_c ? paint_green : '0;
    res_c.blue        = hit_c ? paint_blue  : '0;
  end

  // output register plus skid entry
  tsp_pkg::result_t out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= iv;
      end
    end else if (iv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (iv) begin
        out_data <= res_c;
      end
    end else if (iv) begin
      skid_data <= res_c;
    end
  end

  assign hit         = out_data.hit;
  assign pixel_index = out_data.pixel_index;
  assign out_red     = out_data.red;
  assign out_green   = out_data.green;
  assign out_blue    = out_data.blue;

endmodule

`default_nettype wire

@@ rtl/core/tsp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "thick_segment_pixel_test_macros.svh"

module tsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         hit,
  input logic [tsp_pkg::IDX_W-1:0]    pixel_index,
  input logic [tsp_pkg::COLOR_W-1:0]  out_red,
  input logic [tsp_pkg::COLOR_W-1:0]  out_green,
  input logic [tsp_pkg::COLOR_W-1:0]  out_blue
);

  // a stalled result holds
  `TSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(pixel_index) && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result changed")

  // input side only backs up after the output was stalled
  `TSP_ASSERT_IMP(a_ready_drop, $fell(in_ready), $past(out_valid) && !$past(out_ready), "in_ready fell without output stall")

  // skid entry full implies output register full
  `TSP_ASSERT_IMP(a_skid_order, !in_ready, out_valid, "in_ready low with empty output")

  // a miss carries no color
  `TSP_ASSERT_IMP(a_miss_black, out_valid && !hit, (out_red == '0) && (out_green == '0) && (out_blue == '0), "color on a miss")

endmodule

bind thick_segment_pixel_test tsp_checker u_tsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .pixel_index (pixel_index),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue)
);

`default_nettype wire

@@ bench/thick_segment_pixel_test_test.sv @@
`timescale 1ns / 1ps

module thick_segment_pixel_test_test;

  localparam int IDLE_LIMIT = 4000;

  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [tsp_pkg::PIX_W-1:0]      pixel_col = '0;
  logic [tsp_pkg::PIX_W-1:0]      pixel_row = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           hit;
  logic [tsp_pkg::IDX_W-1:0]      pixel_index;
  logic [tsp_pkg::COLOR_W-1:0]    out_red;
  logic [tsp_pkg::COLOR_W-1:0]    out_green;
  logic [tsp_pkg::COLOR_W-1:0]    out_blue;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tsp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the segment registers
  logic signed [14:0] seg_x0, seg_y0, seg_x1, seg_y1;
  logic [9:0]         seg_width;
  logic [7:0]         paint_r, paint_g, paint_b;

  tsp_pkg::result_t expected_px_q[$];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       gap_max = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_FREE;
  logic [15:0] stall_pat = 16'hffff;
  logic [3:0]  rx_tick = '0;

  thick_segment_pixel_test u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .pixel_index (pixel_index),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // projection of the pixel onto the segment in Q1.16, then squared distance vs thickness
  function automatic tsp_pkg::result_t predict_pixel(input logic [8:0] col,
                                                     input logic [8:0] row);
    longint x0, y0, px, py, dx, dy, len2, dot, t, ex, ey, idx;
    longint unsigned ax, ay, d2, lim;
    tsp_pkg::result_t r;
    x0   = longint'(seg_x0);
    y0   = longint'(seg_y0);
    dx   = longint'(seg_x1) - x0;
    dy   = longint'(seg_y1) - y0;
    px   = longint'(col) * 16;
    py   = longint'(row) * 16;
    len2 = dx * dx + dy * dy;
    r.hit = 1'b0;
    if (len2 != 0 && col < tsp_pkg::IMAGE_WIDTH && row < tsp_pkg::IMAGE_HEIGHT) begin
      dot = (px - x0) * dx + (py - y0) * dy;
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = 65536;
      else t = (dot * 65536) / len2;
      ex  = px * 65536 - (x0 * 65536 + t * dx);
      ey  = py * 65536 - (y0 * 65536 + t * dy);
      ax  = (ex < 0) ? -ex : ex;
      ay  = (ey < 0) ? -ey : ey;
      d2  = ax * ax + ay * ay;
      lim = seg_width;
      lim = (lim * lim) << 30;
      r.hit = (d2 <= lim);
    end
    idx = longint'(row) * tsp_pkg::IMAGE_WIDTH + longint'(col);
    r.pixel_index = idx[tsp_pkg::IDX_W-1:0];
    r.red   = r.hit ? paint_r : '0;
    r.green = r.hit ? paint_g : '0;
    r.blue  = r.hit ? paint_b : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    tsp_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_px_q.size() == 0) begin
        report_mismatch("unexpected item, pixel_index", pixel_index, -1);
      end else begin
        want = expected_px_q.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", pixel_index, want.pixel_index);
        if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
      end
    end
  end

  always @(posedge clk) begin
    case (rx_mode)
      RX_FREE:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: begin
        out_ready <= stall_pat[rx_tick];
        rx_tick   <= rx_tick + 4'd1;
      end
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[thick_segment_pixel_test] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input tsp_pkg::cfg_reg_t idx, input logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tsp_pkg::REG_START_X:     seg_x0    = data;
      tsp_pkg::REG_START_Y:     seg_y0    = data;
      tsp_pkg::REG_END_X:       seg_x1    = data;
      tsp_pkg::REG_END_Y:       seg_y1    = data;
      tsp_pkg::REG_LINE_WIDTH:  seg_width = data[9:0];
      tsp_pkg::REG_PAINT_RED:   paint_r   = data[7:0];
      tsp_pkg::REG_PAINT_GREEN: paint_g   = data[7:0];
      tsp_pkg::REG_PAINT_BLUE:  paint_b   = data[7:0];
      default: ;
    endcase
  endtask

  // unused upper data bits get random filler, the block must drop them
  task automatic set_config(input int x0, input int y0, input int x1, input int y1,
                            input int w, input int r, input int g, input int b);
    logic [4:0] pad_w;
    logic [6:0] pad_r, pad_g, pad_b;
    pad_w = 5'($urandom);
    pad_r = 7'($urandom);
    pad_g = 7'($urandom);
    pad_b = 7'($urandom);
    write_reg(tsp_pkg::REG_START_X, 15'(x0));
    write_reg(tsp_pkg::REG_START_Y, 15'(y0));
    write_reg(tsp_pkg::REG_END_X, 15'(x1));
    write_reg(tsp_pkg::REG_END_Y, 15'(y1));
    write_reg(tsp_pkg::REG_LINE_WIDTH, {pad_w, 10'(w)});
    write_reg(tsp_pkg::REG_PAINT_RED, {pad_r, 8'(r)});
    write_reg(tsp_pkg::REG_PAINT_GREEN, {pad_g, 8'(g)});
    write_reg(tsp_pkg::REG_PAINT_BLUE, {pad_b, 8'(b)});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [8:0] col, input logic [8:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid  <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_px_q.push_back(predict_pixel(col, row));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_px_q.size() != 0) @(posedge clk);
    repeat (tsp_pkg::STAGES + 4) @(posedge clk);
  endtask

  task automatic set_idling(input int gaps, input rx_mode_t mode);
    gap_max = gaps;
    rx_mode <= mode;
    stall_pat <= 16'($urandom) | 16'h0001;
  endtask

  // pixel close to a random point of the current segment
  function automatic logic [17:0] near_pixel();
    int f, cx, cy, reach, c, r;
    f     = $urandom_range(0, 1024);
    cx    = int'(seg_x0) + ((int'(seg_x1) - int'(seg_x0)) * f) / 1024;
    cy    = int'(seg_y0) + ((int'(seg_y1) - int'(seg_y0)) * f) / 1024;
    reach = int'(seg_width) + 48;
    c = (cx + int'($urandom_range(0, 2 * reach)) - reach + 8) / 16;
    r = (cy + int'($urandom_range(0, 2 * reach)) - reach + 8) / 16;
    if (c < 0) c = 0;
    if (c > 511) c = 511;
    if (r < 0) r = 0;
    if (r > 511) r = 511;
    return {9'(r), 9'(c)};
  endfunction

  // registers at reset: zero-length segment, nothing hits
  task automatic test_reset_state();
    set_idling(0, RX_FREE);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    drain_pipeline();
  endtask

  // horizontal segment, radius one pixel: caps and side edges sit exactly on the limit
  task automatic test_horizontal_caps();
    set_config(160, 320, 480, 320, 32, 255, 0, 170);
    set_idling(3, RX_RANDOM);
    send_pixel(9'd10, 9'd20);
    send_pixel(9'd30, 9'd20);
    send_pixel(9'd20, 9'd20);
    send_pixel(9'd20, 9'd21);
    send_pixel(9'd20, 9'd22);
    send_pixel(9'd8, 9'd20);
    send_pixel(9'd9, 9'd20);
    send_pixel(9'd31, 9'd20);
    send_pixel(9'd32, 9'd20);
    drain_pipeline();
  endtask

  // zero thickness: only pixels exactly on the segment hit
  task automatic test_zero_thickness();
    set_config(0, 0, 1600, 800, 0, 17, 34, 51);
    set_idling(0, RX_PATTERN);
    send_pixel(9'd50, 9'd25);
    send_pixel(9'd51, 9'd25);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd100, 9'd50);
    drain_pipeline();
  endtask

  task automatic test_extreme_config();
    set_config(-16384, -16384, 16383, 16383, 1023, 1, 2, 3);
    set_idling(5, RX_SLOW);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    drain_pipeline();
  endtask

  task automatic test_random_segments(input int phases, input int per_phase);
    int x0, y0, x1, y1, w;
    logic [17:0] rc;
    for (int p = 0; p < phases; p++) begin
      x0 = $urandom_range(0, 8191);
      y0 = $urandom_range(0, 8191);
      case ($urandom_range(0, 4))
        0: begin
          x1 = $urandom_range(0, 8191);
          y1 = $urandom_range(0, 8191);
        end
        1: begin
          x0 = int'($urandom_range(0, 32767)) - 16384;
          y0 = int'($urandom_range(0, 32767)) - 16384;
          x1 = int'($urandom_range(0, 32767)) - 16384;
          y1 = int'($urandom_range(0, 32767)) - 16384;
        end
        2: begin
          x0 = $urandom_range(0, 1) ? 16383 : -16384;
          y0 = $urandom_range(0, 1) ? 16383 : -16384;
          x1 = $urandom_range(0, 1) ? 16383 : -16384;
          y1 = $urandom_range(0, 1) ? 16383 : -16384;
        end
        3: begin
          x1 = x0;
          y1 = y0;
        end
        default: begin
          x1 = x0 + int'($urandom_range(0, 64)) - 32;
          y1 = y0 + int'($urandom_range(0, 64)) - 32;
        end
      endcase
      case ($urandom_range(0, 5))
        0:       w = 0;
        1:       w = 1023;
        2:       w = $urandom_range(0, 63);
        default: w = $urandom_range(0, 1023);
      endcase
      set_config(x0, y0, x1, y1, w, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
      set_idling((p % 3 == 0) ? 0 : $urandom_range(1, 24), rx_mode_t'(p % 4));
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          rc = near_pixel();
          send_pixel(rc[8:0], rc[17:9]);
        end else begin
          send_pixel(9'($urandom), 9'($urandom));
        end
      end
      drain_pipeline();
    end
  endtask

  initial begin
    seg_x0 = '0;
    seg_y0 = '0;
    seg_x1 = '0;
    seg_y1 = '0;
    seg_width = 10'd128;
    paint_r = '0;
    paint_g = '0;
    paint_b = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_horizontal_caps();
    test_zero_thickness();
    test_extreme_config();
    test_random_segments(12, 100);
    if (mismatch_count == 0) begin
      $display("[thick_segment_pixel_test] OK");
    end else begin
      $display("[thick_segment_pixel_test] ERROR");
    end
    $finish;
  end

endmodule
